### design/cps_pkg.sv
`default_nettype none

package cps_pkg;

    // Field widths fixed by the word formats
    localparam int SLOT_W = 6;
    localparam int PRIO_W = 6;
    localparam int CNT_W  = 8;

    // Defaults for the top-level parameters
    localparam int DEF_SLOTS        = 64;
    localparam int DEF_MAX_PRIORITY = 63;

    // Counter value meaning "nothing picked yet"
    localparam logic signed [CNT_W-1:0] CNT_NONE = -8'sd1;
    localparam logic signed [CNT_W-1:0] CNT_MAX  = 8'sd127;

    typedef enum logic [1:0] {
        CMD_SET      = 2'd0,
        CMD_CREATE   = 2'd1,
        CMD_REMOVE   = 2'd2,
        CMD_SCHEDULE = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [SLOT_W-1:0] slot;
        logic [PRIO_W-1:0] prio;
        logic              ready_value;
    } req_word_t;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] granted_slot;
        logic              recomputed;
        logic              none_ready;
    } rsp_word_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;           // request word accepted
        logic scan_clear;     // restart table scan
        logic refresh_start;  // restart scan with counter refresh
        logic scan_en;        // issue one table read
        logic grant;          // commit pick to the table
        logic set_none;       // flag: no ready slot
        logic emit;           // load response register
    } ctl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic req_is_sched;   // pending request is a schedule
        logic last_issue;     // scan index at last slot
        logic any_ready;      // scan saw a present, ready slot
        logic found;          // scan picked a slot
        logic refreshing;     // refresh pass already done
        logic rsp_free;       // response register can take a word
    } dp_status_t;

endpackage

`default_nettype wire

### design/counter_priority_scheduler.sv
// Counter-based priority scheduler over SLOTS task slots. Each request word
// carries one command: set a slot's ready mark, create a slot (counter loaded
// with its priority, clamped to 1..MAX_PRIORITY), remove a slot, or schedule.
// Every request returns exactly one response word, in order. Set, create and
// remove need no table scan. A schedule scans the counter table one slot per
// cycle through a single read port, and a refresh pass (counters halved plus
// priority) adds another scan of the table. The response register holds a
// finished word while the next request is taken; a new request is accepted
// whenever the block is idle.
`default_nettype none

module counter_priority_scheduler #(
    parameter int SLOTS        = cps_pkg::DEF_SLOTS,
    parameter int MAX_PRIORITY = cps_pkg::DEF_MAX_PRIORITY
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    output logic                 req_ready,
    input  cps_pkg::req_word_t   req,
    output logic                 rsp_valid,
    input  wire                  rsp_ready,
    output cps_pkg::rsp_word_t   rsp
);
    import cps_pkg::*;

    // Command and status between sequencer and datapath
    ctl_cmd_t   ctl;
    dp_status_t status;

    // Sequencer: idle / scan / drain / decide / grant / respond
    cps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .status    (status),
        .ctl       (ctl),
        .req_ready (req_ready)
    );

    // Datapath: slot marks, priority/counter tables, scan pick,
    // refresh arithmetic and the response register
    cps_datapath #(
        .SLOTS        (SLOTS),
        .MAX_PRIORITY (MAX_PRIORITY)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ready (rsp_ready),
        .ctl       (ctl),
        .status    (status),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

    // A table update accepted with an empty response register is answered via the respond state without a stall
    a_update_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.cmd != CMD_SCHEDULE) && !rsp_valid)
        |-> ##2 rsp_valid)
        else $error("table update response late");

    // A response is loaded only while the block is busy
    a_rsp_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("response loaded while idle");

    // Outcome flags are mutually consistent
    a_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.granted && rsp.none_ready)
                      && !(rsp.none_ready && rsp.recomputed))
        else $error("inconsistent schedule outcome");

endmodule

`default_nettype wire

### design/cps_ctrl.sv
`default_nettype none

module cps_ctrl (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    req_valid,
    input  cps_pkg::dp_status_t    status,
    output cps_pkg::ctl_cmd_t      ctl,
    output logic                   req_ready
);
    import cps_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_DECIDE = 6'b001000,
        ST_GRANT  = 6'b010000,
        ST_RESP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    ctl.load = 1'b1;
                    if (status.req_is_sched)
                    begin
                        ctl.scan_clear = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN:
            begin
                ctl.scan_en = 1'b1;
                if (status.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (!status.any_ready)
                begin
                    ctl.set_none = 1'b1;
                    state_next   = ST_RESP;
                end
                else if (status.found)
                begin
                    state_next = ST_GRANT;
                end
                else if (!status.refreshing)
                begin
                    ctl.refresh_start = 1'b1;
                    state_next        = ST_SCAN;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_GRANT:
            begin
                ctl.grant  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (status.rsp_free)
                begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/cps_datapath.sv
`default_nettype none

module cps_datapath #(
    parameter int SLOTS        = cps_pkg::DEF_SLOTS,
    parameter int MAX_PRIORITY = cps_pkg::DEF_MAX_PRIORITY
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  cps_pkg::req_word_t     req,
    input  wire                    rsp_ready,
    input  cps_pkg::ctl_cmd_t      ctl,
    output cps_pkg::dp_status_t    status,
    output cps_pkg::rsp_word_t     rsp,
    output logic                   rsp_valid
);
    import cps_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CMP_W = 9;
    localparam logic [CMP_W-1:0] SLOTS_CMP = CMP_W'(SLOTS);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SLOTS - 1);
    localparam logic [7:0]       MAXP      = 8'(MAX_PRIORITY);

    // Per-slot marks in flops, cleared by reset
    logic [SLOTS-1:0] present_reg;
    logic [SLOTS-1:0] ready_reg;

    // Priority and counter tables
    logic [PRIO_W-1:0]       prio_mem [SLOTS];
    logic signed [CNT_W-1:0] cnt_mem  [SLOTS];

    // Scan state
    logic [IDX_W-1:0]        idx_reg;
    logic                    rd_v_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic signed [CNT_W-1:0] cnt_rd_reg;
    logic [PRIO_W-1:0]       prio_rd_reg;
    logic signed [CNT_W-1:0] best_cnt_reg;
    logic [IDX_W-1:0]        best_idx_reg;
    logic                    any_reg;
    logic                    refresh_reg;
    logic                    granted_reg;
    logic                    none_reg;

    rsp_word_t rsp_reg;
    logic      rsp_valid_reg;

    // Request decode
    logic              slot_in_range;
    logic [IDX_W-1:0]  req_idx;
    logic [PRIO_W-1:0] prio_clamped;
    logic              do_update;

    assign slot_in_range = (CMP_W'(req.slot) < SLOTS_CMP);
    assign req_idx       = IDX_W'(req.slot);
    assign do_update     = ctl.load && (req.cmd != CMD_SCHEDULE) && slot_in_range;

    always_comb
    begin
        prio_clamped = req.prio;
        if (req.prio == '0)
        begin
            prio_clamped = PRIO_W'(1);
        end
        else if ({2'b00, req.prio} > MAXP)
        begin
            prio_clamped = PRIO_W'(MAXP);
        end
    end

    // Refresh value: floor(c/2) + prio, saturated
    logic signed [CNT_W-1:0] half_cnt;
    logic signed [CNT_W:0]   sum_cnt;
    logic signed [CNT_W-1:0] refresh_cnt;
    logic signed [CNT_W-1:0] cmp_cnt;
    logic                    rd_elig;
    logic                    rd_present;

    assign half_cnt   = cnt_rd_reg >>> 1;
    assign sum_cnt    = $signed({half_cnt[CNT_W-1], half_cnt})
                      + $signed({{(CNT_W+1-PRIO_W){1'b0}}, prio_rd_reg});
    assign refresh_cnt = (sum_cnt > $signed({1'b0, CNT_MAX})) ? CNT_MAX
                                                              : sum_cnt[CNT_W-1:0];
    assign rd_present = present_reg[rd_idx_reg];
    assign rd_elig    = rd_present && ready_reg[rd_idx_reg];
    assign cmp_cnt    = refresh_reg ? refresh_cnt : cnt_rd_reg;

    // Table memories: one write, one read per cycle
    always_ff @(posedge clk)
    begin
        if (do_update && (req.cmd == CMD_CREATE))
        begin
            prio_mem[req_idx] <= prio_clamped;
        end
        prio_rd_reg <= prio_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (do_update && (req.cmd == CMD_CREATE))
        begin
            cnt_mem[req_idx] <= $signed({{(CNT_W-PRIO_W){1'b0}}, prio_clamped});
        end
        else if (rd_v_reg && refresh_reg && rd_present)
        begin
            cnt_mem[rd_idx_reg] <= refresh_cnt;
        end
        else if (ctl.grant)
        begin
            cnt_mem[best_idx_reg] <= best_cnt_reg - 8'sd1;
        end
        cnt_rd_reg <= cnt_mem[idx_reg];
    end

    // Marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            ready_reg   <= '0;
        end
        else if (do_update)
        begin
            case (req.cmd)
                CMD_SET:
                begin
                    if (present_reg[req_idx])
                    begin
                        ready_reg[req_idx] <= req.ready_value;
                    end
                end
                CMD_CREATE:
                begin
                    present_reg[req_idx] <= 1'b1;
                    ready_reg[req_idx]   <= req.ready_value;
                end
                default:
                begin
                    present_reg[req_idx] <= 1'b0;
                    ready_reg[req_idx]   <= 1'b0;
                end
            endcase
        end
        else if (ctl.grant)
        begin
            ready_reg[best_idx_reg] <= 1'b0;
        end
    end

    // Scan control and pick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            rd_v_reg     <= 1'b0;
            rd_idx_reg   <= '0;
            best_cnt_reg <= CNT_NONE;
            best_idx_reg <= '0;
            any_reg      <= 1'b0;
            refresh_reg  <= 1'b0;
            granted_reg  <= 1'b0;
            none_reg     <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= ctl.scan_en;
            rd_idx_reg <= idx_reg;
            if (ctl.load)
            begin
                refresh_reg <= 1'b0;
                granted_reg <= 1'b0;
                none_reg    <= 1'b0;
            end
            if (ctl.refresh_start)
            begin
                refresh_reg <= 1'b1;
            end
            if (ctl.grant)
            begin
                granted_reg <= 1'b1;
            end
            if (ctl.set_none)
            begin
                none_reg <= 1'b1;
            end
            if (ctl.scan_clear || ctl.refresh_start)
            begin
                idx_reg      <= '0;
                best_cnt_reg <= CNT_NONE;
                best_idx_reg <= '0;
                any_reg      <= 1'b0;
            end
            else
            begin
                if (ctl.scan_en)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (rd_v_reg && rd_elig)
                begin
                    any_reg <= 1'b1;
                    if (cmp_cnt > best_cnt_reg)
                    begin
                        best_cnt_reg <= cmp_cnt;
                        best_idx_reg <= rd_idx_reg;
                    end
                end
            end
        end
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            rsp_reg.granted      <= granted_reg;
            rsp_reg.granted_slot <= granted_reg ? SLOT_W'(best_idx_reg) : '0;
            rsp_reg.recomputed   <= refresh_reg;
            rsp_reg.none_ready   <= none_reg;
        end
    end

    assign status.req_is_sched = (req.cmd == CMD_SCHEDULE);
    assign status.last_issue   = (idx_reg == IDX_LAST);
    assign status.any_ready    = any_reg;
    assign status.found        = !best_cnt_reg[CNT_W-1];
    assign status.refreshing   = refresh_reg;
    assign status.rsp_free     = !rsp_valid_reg || rsp_ready;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

### tb/tb_counter_priority_scheduler.sv
`default_nettype none

module tb_counter_priority_scheduler;
    import cps_pkg::*;

    // Block configuration under test
    localparam int NSLOT = DEF_SLOTS;
    localparam int MAXP  = DEF_MAX_PRIORITY;

    // Run shape
    localparam int PLAN_ROWS     = 25;
    localparam int RANDOM_WORDS  = 1200;
    localparam int GAP_MAX       = 11;
    // Long receiver hold-off: block fills its response register and stalls requests
    localparam int PRESSURE_AT   = 300;
    localparam int PRESSURE_HOLD = 400;
    // The long hold-off, not a schedule with refresh, sets the stall limit
    localparam int STALL_LIMIT   = 3000;
    localparam int DRAIN_CYCLES  = 2 * NSLOT + 32;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      rsp_ready = 1'b0;
    req_word_t req       = '0;
    logic      req_ready;
    logic      rsp_valid;
    rsp_word_t rsp;

    counter_priority_scheduler #(
        .SLOTS       (NSLOT),
        .MAX_PRIORITY(MAXP)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Single reset at start, released on a rising edge
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Shadow of the slot table. Counters kept as int; they stay in -1..127.
    // ------------------------------------------------------------------
    bit slot_here [NSLOT];
    bit slot_rdy  [NSLOT];
    int slot_prio [NSLOT];
    int slot_cnt  [NSLOT];

    // Response words owed by the block, oldest first
    rsp_word_t sched_outcomes_q[$];

    int  mismatches  = 0;
    int  n_sched     = 0;
    int  n_grants    = 0;
    int  n_refresh   = 0;
    int  n_idle      = 0;
    int  n_rsp_seen  = 0;
    bit  words_done  = 1'b0;

    // Ready, present slot with the largest non-negative counter; lowest wins ties
    function automatic int pick_runnable();
        int best;
        int best_cnt;
        best     = -1;
        best_cnt = -1;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (slot_here[i] && slot_rdy[i] && slot_cnt[i] > best_cnt)
            begin
                best     = i;
                best_cnt = slot_cnt[i];
            end
        end
        return best;
    endfunction

    // Apply one command word to the shadow table and return the response word
    task automatic advance_slot_table(input req_word_t w, output rsp_word_t r);
        int  pick;
        int  p;
        int  v;
        bit  any;
        r = '0;
        if (w.cmd == CMD_SCHEDULE)
        begin
            n_sched++;
            any = 1'b0;
            for (int i = 0; i < NSLOT; i++)
                if (slot_here[i] && slot_rdy[i])
                    any = 1'b1;
            if (!any)
            begin
                r.none_ready = 1'b1;
                n_idle++;
            end
            else
            begin
                pick = pick_runnable();
                if (pick < 0)
                begin
                    // every ready counter is negative: halve (floor) plus priority
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (slot_here[i])
                        begin
                            v = (slot_cnt[i] >>> 1) + slot_prio[i];
                            slot_cnt[i] = (v > 127) ? 127 : v;
                        end
                    end
                    r.recomputed = 1'b1;
                    n_refresh++;
                    pick = pick_runnable();
                end
                if (pick >= 0)
                begin
                    slot_cnt[pick]--;
                    slot_rdy[pick] = 1'b0;
                    r.granted      = 1'b1;
                    r.granted_slot = SLOT_W'(pick);
                    n_grants++;
                end
            end
        end
        else if (int'(w.slot) < NSLOT)
        begin
            case (w.cmd)
                CMD_SET:
                begin
                    if (slot_here[w.slot])
                        slot_rdy[w.slot] = w.ready_value;
                end
                CMD_CREATE:
                begin
                    p = int'(w.prio);
                    if (p < 1)
                        p = 1;
                    if (p > MAXP)
                        p = MAXP;
                    slot_here[w.slot] = 1'b1;
                    slot_rdy[w.slot]  = w.ready_value;
                    slot_prio[w.slot] = p;
                    slot_cnt[w.slot]  = p;
                end
                default:
                begin
                    slot_here[w.slot] = 1'b0;
                    slot_rdy[w.slot]  = 1'b0;
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Directed plan. Rows marked typed carry a hand-written response word;
    // the rest take the shadow table's answer.
    // ------------------------------------------------------------------
    typedef struct {
        req_word_t word;
        bit        typed;
        rsp_word_t want;
    } plan_row_t;

    plan_row_t plan[PLAN_ROWS];

    function automatic rsp_word_t mk_rsp(bit g, int s, bit rc, bit nr);
        rsp_word_t r;
        r.granted      = g;
        r.granted_slot = SLOT_W'(s);
        r.recomputed   = rc;
        r.none_ready   = nr;
        return r;
    endfunction

    function automatic plan_row_t row(cmd_t c, int s, int p, bit rv, bit typed,
                                      rsp_word_t want);
        plan_row_t pr;
        pr.word.cmd         = c;
        pr.word.slot        = SLOT_W'(s);
        pr.word.prio        = PRIO_W'(p);
        pr.word.ready_value = rv;
        pr.typed            = typed;
        pr.want             = want;
        return pr;
    endfunction

    initial
    begin
        rsp_word_t quiet;
        rsp_word_t idle_rsp;
        quiet    = mk_rsp(0, 0, 0, 0);
        idle_rsp = mk_rsp(0, 0, 0, 1);
        plan[0]  = row(CMD_SCHEDULE, 0, 0, 0, 1, idle_rsp);  // empty table after reset
        plan[1]  = row(CMD_SET, 5, 0, 1, 1, quiet);          // set on absent slot
        plan[2]  = row(CMD_REMOVE, 7, 0, 0, 1, quiet);       // remove absent slot
        plan[3]  = row(CMD_CREATE, 0, 0, 1, 1, quiet);       // prio 0 clamps to 1
        plan[4]  = row(CMD_CREATE, 63, 63, 1, 1, quiet);     // top slot, top prio
        plan[5]  = row(CMD_CREATE, 10, 63, 1, 1, quiet);
        plan[6]  = row(CMD_SCHEDULE, 0, 0, 0, 1, mk_rsp(1, 10, 0, 0)); // tie -> lower
        plan[7]  = row(CMD_SCHEDULE, 0, 0, 0, 1, mk_rsp(1, 63, 0, 0));
        plan[8]  = row(CMD_SCHEDULE, 0, 0, 0, 1, mk_rsp(1, 0, 0, 0));
        plan[9]  = row(CMD_SCHEDULE, 0, 0, 0, 1, idle_rsp);  // all running now
        plan[10] = row(CMD_SET, 0, 0, 1, 1, quiet);
        plan[11] = row(CMD_SCHEDULE, 0, 0, 0, 1, mk_rsp(1, 0, 0, 0)); // counter 0 -> -1
        plan[12] = row(CMD_SET, 0, 0, 1, 1, quiet);
        plan[13] = row(CMD_SCHEDULE, 0, 0, 0, 1, mk_rsp(1, 0, 1, 0)); // forces refresh
        plan[14] = row(CMD_CREATE, 0, 5, 0, 1, quiet);       // re-create present slot
        plan[15] = row(CMD_SET, 10, 0, 1, 1, quiet);
        plan[16] = row(CMD_SET, 63, 0, 1, 1, quiet);
        plan[17] = row(CMD_SCHEDULE, 0, 0, 0, 0, quiet);
        plan[18] = row(CMD_SET, 10, 0, 0, 1, quiet);         // clear a ready mark
        plan[19] = row(CMD_SCHEDULE, 0, 0, 0, 0, quiet);
        plan[20] = row(CMD_REMOVE, 63, 0, 0, 1, quiet);
        plan[21] = row(CMD_SET, 63, 0, 1, 1, quiet);         // removed slot ignores set
        plan[22] = row(CMD_SCHEDULE, 0, 0, 0, 1, idle_rsp);
        plan[23] = row(CMD_CREATE, 42, 42, 1, 1, quiet);
        plan[24] = row(CMD_SCHEDULE, 0, 0, 0, 0, quiet);
    end

    // Random command word. Slots and priorities lean small so counters drain
    // and refresh passes come often; the full range still shows up.
    function automatic req_word_t draw_sched_word();
        req_word_t w;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            w.cmd = CMD_SCHEDULE;
        else if (pick < 72)
            w.cmd = CMD_SET;
        else if (pick < 90)
            w.cmd = CMD_CREATE;
        else
            w.cmd = CMD_REMOVE;
        w.slot        = ($urandom_range(0, 3) != 0) ? SLOT_W'($urandom_range(0, 7))
                                                    : SLOT_W'($urandom_range(0, 63));
        w.prio        = ($urandom_range(0, 3) != 0) ? PRIO_W'($urandom_range(0, 7))
                                                    : PRIO_W'($urandom_range(0, 63));
        w.ready_value = ($urandom_range(0, 4) != 0);
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Request side: directed rows, then random words. Gaps up to GAP_MAX per word,
    // with stretches of back-to-back words. Valid holds until accepted.
    // ------------------------------------------------------------------
    initial
    begin
        req_word_t w;
        rsp_word_t pred;
        int        gap;
        bit        steady;
        steady = 1'b0;
        wait (rst_n === 1'b1);
        for (int n = 0; n < PLAN_ROWS + RANDOM_WORDS; n++)
        begin
            if (n % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            w   = (n < PLAN_ROWS) ? plan[n].word : draw_sched_word();
            gap = steady ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            req_valid <= 1'b1;
            req       <= w;
            do
                @(posedge clk);
            while (!req_ready);
            // word taken at this edge: predict its response
            advance_slot_table(w, pred);
            if (n < PLAN_ROWS && plan[n].typed)
                sched_outcomes_q.push_back(plan[n].want);
            else
                sched_outcomes_q.push_back(pred);
        end
        req_valid <= 1'b0;
        words_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // Response side: random stalls, one long hold-off, field-by-field check.
    // ------------------------------------------------------------------
    initial
    begin
        rsp_word_t want;
        int        hold;
        bit        steady;
        steady = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (n_rsp_seen % 40 == 0)
                steady = ($urandom_range(0, 3) == 0);
            hold = steady ? 0 : $urandom_range(0, GAP_MAX);
            if (n_rsp_seen == PRESSURE_AT)
                hold = PRESSURE_HOLD;
            if (hold > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_valid !== 1'b1);
            n_rsp_seen++;
            if (sched_outcomes_q.size() == 0)
                report_mismatch($sformatf("response word with nothing owed: %p", rsp));
            else
            begin
                want = sched_outcomes_q.pop_front();
                if (rsp.granted !== want.granted)
                    report_mismatch($sformatf("word %0d granted %b, want %b",
                                              n_rsp_seen, rsp.granted, want.granted));
                if (rsp.granted_slot !== want.granted_slot)
                    report_mismatch($sformatf("word %0d granted_slot %0d, want %0d",
                                              n_rsp_seen, rsp.granted_slot,
                                              want.granted_slot));
                if (rsp.recomputed !== want.recomputed)
                    report_mismatch($sformatf("word %0d recomputed %b, want %b",
                                              n_rsp_seen, rsp.recomputed, want.recomputed));
                if (rsp.none_ready !== want.none_ready)
                    report_mismatch($sformatf("word %0d none_ready %b, want %b",
                                              n_rsp_seen, rsp.none_ready, want.none_ready));
            end
        end
    end

    // Watchdog: too long with no word moving on either channel
    initial
    begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // End of run: all words sent, all responses in, then a quiet tail that
    // would expose any stray response word.
    initial
    begin
        wait (words_done);
        while (sched_outcomes_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run: %0d command words, %0d schedules (%0d grants, %0d refresh passes,",
                 PLAN_ROWS + RANDOM_WORDS, n_sched, n_grants, n_refresh);
        $display("     %0d with nothing ready), %0d response words checked, %0d mismatches",
                 n_idle, n_rsp_seen, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
